// ----- hdl/hsp_pkg.sv -----
// ----------------------------------------------------------------------------
// hsp_pkg: shared types and constants for the HTTP response stream parser
// Holds the item types, result and action codes and the header literal
// tables that drive the name/value matchers.
// ----------------------------------------------------------------------------
`default_nettype none
package hsp_pkg;

  localparam int LENGTH_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] RC_NEED_MORE = 3'd0;
  localparam logic [2:0] RC_COMPLETE  = 3'd1;
  localparam logic [2:0] RC_BAD       = 3'd2;
  localparam logic [2:0] RC_VERSION   = 3'd3;
  localparam logic [2:0] RC_TOO_LARGE = 3'd4;
  localparam logic [2:0] RC_SWITCHING = 3'd5;

  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_CLOSE   = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Classified input item as it travels through the queue
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [7:0] lc;
    logic       is_dig;
    logic [3:0] dval;
    logic       is_hex;
    logic [3:0] hval;
    logic       is_ctl;
    logic       is_tok;
  } hsp_item_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic [15:0] status_value;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic        keep_alive;
    logic [31:0] body_length;
    logic        length_known;
    logic        chunked;
  } hsp_result_t;

  localparam int LIT_BYTES = 17;
  localparam logic [8*LIT_BYTES-1:0] NAME_LIT0 = "content-length";
  localparam logic [8*LIT_BYTES-1:0] NAME_LIT1 = "transfer-encoding";
  localparam logic [8*LIT_BYTES-1:0] NAME_LIT2 = "connection";
  localparam logic [8*LIT_BYTES-1:0] VAL_LIT0  = "chunked";
  localparam logic [8*LIT_BYTES-1:0] VAL_LIT1  = "close";
  localparam logic [8*LIT_BYTES-1:0] VAL_LIT2  = "keep-alive";
  localparam logic [4:0] NAME_LEN0 = 5'd14;
  localparam logic [4:0] NAME_LEN1 = 5'd17;
  localparam logic [4:0] NAME_LEN2 = 5'd10;
  localparam logic [4:0] VAL_LEN0  = 5'd7;
  localparam logic [4:0] VAL_LEN1  = 5'd5;
  localparam logic [4:0] VAL_LEN2  = 5'd10;

  function automatic logic [4:0] lit_len(input logic is_val, input logic [1:0] k);
    logic [4:0] l;
    case (k)
      2'd0:    l = is_val ? VAL_LEN0 : NAME_LEN0;
      2'd1:    l = is_val ? VAL_LEN1 : NAME_LEN1;
      default: l = is_val ? VAL_LEN2 : NAME_LEN2;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] lit_char(input logic is_val, input logic [1:0] k,
                                          input logic [4:0] pos);
    logic [8*LIT_BYTES-1:0] lit;
    logic [8*LIT_BYTES-1:0] sh;
    logic [4:0] l;
    case (k)
      2'd0:    lit = is_val ? VAL_LIT0 : NAME_LIT0;
      2'd1:    lit = is_val ? VAL_LIT1 : NAME_LIT1;
      default: lit = is_val ? VAL_LIT2 : NAME_LIT2;
    endcase
    l = lit_len(is_val, k);
    sh = '0;
    if (pos < l) begin
      sh = lit >> (8 * (int'(l) - 1 - int'(pos)));
    end
    return sh[7:0];
  endfunction

  // One matcher step: drop candidates that miss, advance the saturating position
  function automatic logic [7:0] match_step(input logic [7:0] m, input logic [7:0] c,
                                            input logic is_val);
    logic [4:0] pos;
    logic [2:0] cand;
    pos = m[4:0];
    cand = m[7:5];
    for (int k = 0; k < 3; k++) begin
      if (pos >= lit_len(is_val, 2'(k)) || lit_char(is_val, 2'(k), pos) != c) begin
        cand[k] = 1'b0;
      end
    end
    if (pos != 5'd31) begin
      pos = pos + 5'd1;
    end
    return {cand, pos};
  endfunction

  function automatic logic match_hit(input logic [7:0] m, input logic is_val,
                                     input logic [1:0] k);
    return m[5 + k] && (m[4:0] == lit_len(is_val, k));
  endfunction

endpackage
`default_nettype wire

// ----- hdl/hsp_intf.sv -----
// ----------------------------------------------------------------------------
// hsp channel interfaces
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface hsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface hsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_code;
  logic        body_valid;
  logic [7:0]  body_byte;
  logic [15:0] status_value;
  logic [7:0]  version_major;
  logic [7:0]  version_minor;
  logic        keep_alive;
  logic [31:0] body_length;
  logic        length_known;
  logic        chunked;
  modport source (output valid, output result_code, output body_valid, output body_byte,
                  output status_value, output version_major, output version_minor,
                  output keep_alive, output body_length, output length_known,
                  output chunked, input ready);
  modport sink (input valid, input result_code, input body_valid, input body_byte,
                input status_value, input version_major, input version_minor,
                input keep_alive, input body_length, input length_known,
                input chunked, output ready);
endinterface

interface hsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/hsp_front.sv -----
// ----------------------------------------------------------------------------
// hsp_front: input classifier
// Classifies each received octet and pushes the tagged item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module hsp_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_action,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              q_full,
  output logic                   push,
  output hsp_pkg::hsp_item_t     push_item
);
  import hsp_pkg::*;

  logic [7:0] c;
  logic       special;

  assign c = in_data_byte;

  always_comb begin
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
      "{", "}", " ", 8'h09: special = 1'b1;
      default: special = 1'b0;
    endcase
  end

  always_comb begin
    push_item.action    = in_action;
    push_item.data_byte = c;
    push_item.lc        = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    push_item.is_dig    = (c >= "0" && c <= "9");
    push_item.dval      = 4'(c - "0");
    push_item.is_ctl    = (c <= 8'd31) || (c == 8'd127);
    push_item.is_tok    = (c <= 8'd127) && !push_item.is_ctl && !special;
    push_item.is_hex    = 1'b0;
    push_item.hval      = 4'd0;
    if (push_item.is_dig) begin
      push_item.is_hex = 1'b1;
      push_item.hval   = push_item.dval;
    end else if (push_item.lc >= "a" && push_item.lc <= "f") begin
      push_item.is_hex = 1'b1;
      push_item.hval   = 4'(push_item.lc - "a" + 8'd10);
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule
`default_nettype wire

// ----- hdl/hsp_queue.sv -----
// ----------------------------------------------------------------------------
// hsp_queue: short item queue
// Decouples the classifier from the parser so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none
module hsp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  hsp_pkg::hsp_item_t      push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output hsp_pkg::hsp_item_t      head_item
);
  import hsp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  hsp_item_t       mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_r];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_nxt  = push ? bump(wr_r) : wr_r;
    rd_nxt  = pop ? bump(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hsp_back.sv -----
// ----------------------------------------------------------------------------
// hsp_back: response parser engine
// Runs the status line, header and body framing state machine, one item per
// cycle unless an untaken result stalls it; results go to an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module hsp_back #(
  parameter int LENGTH_WIDTH = hsp_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [31:0]       max_body,
  input  wire logic              head_valid,
  input  hsp_pkg::hsp_item_t     head_item,
  output logic                   pop,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output hsp_pkg::hsp_result_t   res
);
  import hsp_pkg::*;

  localparam int W  = LENGTH_WIDTH;
  localparam int CW = (W > 32) ? W : 32;

  localparam logic [4:0] S_H = 5'd0, S_T1 = 5'd1, S_T2 = 5'd2, S_P = 5'd3, S_SLASH = 5'd4,
    S_MAJ0 = 5'd5, S_MAJ = 5'd6, S_MIN0 = 5'd7, S_MIN = 5'd8, S_ST0 = 5'd9, S_ST = 5'd10,
    S_MSG = 5'd11, S_NL1 = 5'd12, S_HSTART = 5'd13, S_LWS = 5'd14, S_HNAME = 5'd15,
    S_SPACE = 5'd16, S_HVAL = 5'd17, S_NL2 = 5'd18, S_NL3 = 5'd19, S_BODY = 5'd20,
    S_CSIZE = 5'd21, S_CEXT = 5'd22, S_CSNL = 5'd23, S_CDATA = 5'd24, S_CDCR = 5'd25,
    S_CDNL = 5'd26, S_TSTART = 5'd27, S_TLINE = 5'd28, S_TLNL = 5'd29, S_TENDNL = 5'd30,
    S_DONE = 5'd31;
  localparam logic [7:0] MATCH_INIT = 8'hE0;

  logic [4:0]   st_r, st_nxt;
  logic [7:0]   maj_r, maj_nxt, min_r, min_nxt;
  logic [15:0]  stat_r, stat_nxt;
  logic [W-1:0] len_r, len_nxt, vnum_r, vnum_nxt, cleft_r, cleft_nxt;
  logic [31:0]  bcnt_r, bcnt_nxt;
  logic         hdr_r, hdr_nxt, nbad_r, nbad_nxt, ndig_r, ndig_nxt, chk_r, chk_nxt;
  logic         keep_r, keep_nxt, lenk_r, lenk_nxt, cdig_r, cdig_nxt;
  logic [7:0]   nm_r, nm_nxt, vm_r, vm_nxt;
  logic [2:0]   held_r, held_nxt;
  logic         out_v_r;
  hsp_result_t  out_r, out_nxt;

  logic [2:0]   code;
  logic         emit, restart_now;
  logic [7:0]   c, lc;

  // Saturating v*10+d and v*16+d by shift-and-add
  function automatic logic [W-1:0] sat_dec(input logic [W-1:0] v, input logic [3:0] d);
    logic [W+3:0] t;
    t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + (W+4)'(d);
    return (t[W+3:W] != 4'd0) ? '1 : t[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_hex(input logic [W-1:0] v, input logic [3:0] d);
    return (v[W-1:W-4] != 4'd0) ? '1 : {v[W-5:0], d};
  endfunction

  function automatic logic [7:0] sat8(input logic [7:0] v, input logic [3:0] d);
    logic [11:0] t;
    t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + 12'(d);
    return (t[11:8] != 4'd0) ? 8'hFF : t[7:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [15:0] v, input logic [3:0] d);
    logic [19:0] t;
    t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + 20'(d);
    return (t[19:16] != 4'd0) ? 16'hFFFF : t[15:0];
  endfunction

  assign pop = head_valid && (!out_v_r || res_ready);
  assign c   = head_item.data_byte;
  assign lc  = head_item.lc;

  always_comb begin
    st_nxt = st_r; maj_nxt = maj_r; min_nxt = min_r; stat_nxt = stat_r;
    len_nxt = len_r; vnum_nxt = vnum_r; cleft_nxt = cleft_r; bcnt_nxt = bcnt_r;
    hdr_nxt = hdr_r; nbad_nxt = nbad_r; ndig_nxt = ndig_r; chk_nxt = chk_r;
    keep_nxt = keep_r; lenk_nxt = lenk_r; cdig_nxt = cdig_r;
    nm_nxt = nm_r; vm_nxt = vm_r; held_nxt = held_r;
    code = RC_NEED_MORE; emit = 1'b0; restart_now = 1'b0;

    if (head_item.action == ACT_BYTE) begin
      case (st_r)
        S_H:  if (c != "H") code = RC_BAD; else st_nxt = S_T1;
        S_T1: if (c != "T") code = RC_BAD; else st_nxt = S_T2;
        S_T2: if (c != "T") code = RC_BAD; else st_nxt = S_P;
        S_P:  if (c != "P") code = RC_BAD; else st_nxt = S_SLASH;
        S_SLASH: begin
          if (c != "/") code = RC_BAD;
          else begin
            maj_nxt = 8'd0; min_nxt = 8'd0; st_nxt = S_MAJ0;
          end
        end
        S_MAJ0, S_MAJ: begin
          if (st_r == S_MAJ && c == ".") st_nxt = S_MIN0;
          else if (!head_item.is_dig) code = RC_BAD;
          else begin
            maj_nxt = sat8(maj_r, head_item.dval); st_nxt = S_MAJ;
          end
        end
        S_MIN0, S_MIN: begin
          if (st_r == S_MIN && c == " ") begin
            st_nxt = S_ST0;
            if (maj_r > 8'd1 || (maj_r == 8'd1 && min_r > 8'd1)) code = RC_VERSION;
            else keep_nxt = (maj_r == 8'd1 && min_r > 8'd0);
          end else if (!head_item.is_dig) code = RC_BAD;
          else begin
            min_nxt = sat8(min_r, head_item.dval); st_nxt = S_MIN;
          end
        end
        S_ST0, S_ST: begin
          if (st_r == S_ST && c == " ") st_nxt = S_MSG;
          else if (st_r == S_ST && c == 8'h0D) st_nxt = S_NL1;
          else if (!head_item.is_dig) code = RC_BAD;
          else begin
            stat_nxt = sat16(stat_r, head_item.dval); st_nxt = S_ST;
          end
        end
        S_MSG: begin
          if (c == 8'h0D) st_nxt = S_NL1;
          else if (head_item.is_ctl) code = RC_BAD;
        end
        S_NL1, S_NL2: if (c != 8'h0A) code = RC_BAD; else st_nxt = S_HSTART;
        S_HSTART: begin
          if (c == 8'h0D) st_nxt = S_NL3;
          else if (hdr_r && (c == " " || c == 8'h09)) st_nxt = S_LWS;
          else if (!head_item.is_tok) code = RC_BAD;
          else begin
            hdr_nxt = 1'b1; nbad_nxt = 1'b0; ndig_nxt = 1'b0;
            nm_nxt = match_step(MATCH_INIT, lc, 1'b0);
            vm_nxt = MATCH_INIT; vnum_nxt = '0; st_nxt = S_HNAME;
          end
        end
        S_LWS, S_HVAL: begin
          if (c == 8'h0D) begin
            st_nxt = S_NL2;
            if (st_r == S_HVAL) begin
              // judge the finished value against the matched header name
              if (match_hit(nm_r, 1'b0, 2'd0)) begin
                if (ndig_r && !nbad_r) begin
                  len_nxt = vnum_r; lenk_nxt = 1'b1;
                end
              end else if (match_hit(nm_r, 1'b0, 2'd1)) begin
                if (match_hit(vm_r, 1'b1, 2'd0)) chk_nxt = 1'b1;
              end else if (match_hit(nm_r, 1'b0, 2'd2)) begin
                if (match_hit(vm_r, 1'b1, 2'd1)) keep_nxt = 1'b0;
                else if (match_hit(vm_r, 1'b1, 2'd2)) keep_nxt = 1'b1;
              end
            end
          end else if (st_r == S_LWS && (c == " " || c == 8'h09)) begin
            st_nxt = S_LWS;
          end else if (head_item.is_ctl) code = RC_BAD;
          else begin
            vm_nxt = match_step(vm_r, lc, 1'b1);
            if (head_item.is_dig) begin
              vnum_nxt = sat_dec(vnum_r, head_item.dval); ndig_nxt = 1'b1;
            end else nbad_nxt = 1'b1;
            st_nxt = S_HVAL;
          end
        end
        S_HNAME: begin
          if (c == ":") st_nxt = S_SPACE;
          else if (!head_item.is_tok) code = RC_BAD;
          else nm_nxt = match_step(nm_r, lc, 1'b0);
        end
        S_SPACE: begin
          if (c == " ") st_nxt = S_HVAL;
          else if (c == 8'h0D) st_nxt = S_NL2;
          else code = RC_BAD;
        end
        S_NL3: begin
          if (c != 8'h0A) code = RC_BAD;
          else if (stat_r == 16'd101) code = RC_SWITCHING;
          else if (stat_r >= 16'd100 && stat_r < 16'd200) restart_now = 1'b1;
          else begin
            bcnt_nxt = 32'd0;
            if (stat_r == 16'd204 || stat_r == 16'd304) code = RC_COMPLETE;
            else if (chk_r) begin
              cleft_nxt = '0; cdig_nxt = 1'b0; st_nxt = S_CSIZE;
            end else if (lenk_r && len_r == '0) code = RC_COMPLETE;
            else st_nxt = S_BODY;
          end
        end
        S_BODY, S_CDATA: begin
          if (bcnt_r >= max_body) code = RC_TOO_LARGE;
          else begin
            bcnt_nxt = bcnt_r + 32'd1;
            emit = 1'b1;
            if (st_r == S_BODY) begin
              if (lenk_r && CW'(bcnt_nxt) >= CW'(len_r)) code = RC_COMPLETE;
            end else begin
              cleft_nxt = cleft_r - W'(1);
              if (cleft_nxt == '0) st_nxt = S_CDCR;
            end
          end
        end
        S_CSIZE: begin
          if (head_item.is_hex) begin
            cdig_nxt = 1'b1; cleft_nxt = sat_hex(cleft_r, head_item.hval);
          end else if ((c == ";" || c == 8'h0D) && cdig_r) begin
            st_nxt = (c == ";") ? S_CEXT : S_CSNL;
          end else code = RC_BAD;
        end
        S_CEXT: if (c == 8'h0D) st_nxt = S_CSNL;
        S_CSNL: begin
          if (c != 8'h0A) code = RC_BAD;
          else st_nxt = (cleft_r == '0) ? S_TSTART : S_CDATA;
        end
        S_CDCR: if (c != 8'h0D) code = RC_BAD; else st_nxt = S_CDNL;
        S_CDNL: begin
          if (c != 8'h0A) code = RC_BAD;
          else begin
            cleft_nxt = '0; cdig_nxt = 1'b0; st_nxt = S_CSIZE;
          end
        end
        S_TSTART: st_nxt = (c == 8'h0D) ? S_TENDNL : S_TLINE;
        S_TLINE:  if (c == 8'h0D) st_nxt = S_TLNL;
        S_TLNL:   if (c != 8'h0A) code = RC_BAD; else st_nxt = S_TSTART;
        S_TENDNL: code = (c != 8'h0A) ? RC_BAD : RC_COMPLETE;
        default:  code = held_r;
      endcase
    end else if (head_item.action == ACT_CLOSE) begin
      if (st_r == S_DONE) code = held_r;
      else if (st_r == S_BODY && !lenk_r) begin
        keep_nxt = 1'b0; code = RC_COMPLETE;
      end else code = RC_BAD;
    end else if (head_item.action == ACT_RESTART) begin
      restart_now = 1'b1;
    end

    // enter the terminal state on any final result
    if (st_r != S_DONE && code != RC_NEED_MORE) begin
      held_nxt = code; st_nxt = S_DONE;
    end

    if (restart_now) begin
      st_nxt = S_H; maj_nxt = '0; min_nxt = '0; stat_nxt = '0; len_nxt = '0;
      bcnt_nxt = '0; cleft_nxt = '0; hdr_nxt = 1'b0; nbad_nxt = 1'b0; ndig_nxt = 1'b0;
      chk_nxt = 1'b0; keep_nxt = 1'b0; lenk_nxt = 1'b0; cdig_nxt = 1'b0;
      nm_nxt = MATCH_INIT; vm_nxt = MATCH_INIT; vnum_nxt = '0; held_nxt = RC_NEED_MORE;
    end

    out_nxt.result_code   = code;
    out_nxt.body_valid    = emit;
    out_nxt.body_byte     = emit ? c : 8'd0;
    out_nxt.status_value  = stat_nxt;
    out_nxt.version_major = maj_nxt;
    out_nxt.version_minor = min_nxt;
    out_nxt.keep_alive    = keep_nxt;
    out_nxt.body_length   = 32'(len_nxt);
    out_nxt.length_known  = lenk_nxt;
    out_nxt.chunked       = chk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_H; maj_r <= '0; min_r <= '0; stat_r <= '0; len_r <= '0;
      bcnt_r <= '0; cleft_r <= '0; hdr_r <= 1'b0; nbad_r <= 1'b0; ndig_r <= 1'b0;
      chk_r <= 1'b0; keep_r <= 1'b0; lenk_r <= 1'b0; cdig_r <= 1'b0;
      nm_r <= MATCH_INIT; vm_r <= MATCH_INIT; vnum_r <= '0; held_r <= RC_NEED_MORE;
      out_v_r <= 1'b0;
    end else begin
      if (pop) begin
        st_r <= st_nxt; maj_r <= maj_nxt; min_r <= min_nxt; stat_r <= stat_nxt;
        len_r <= len_nxt; bcnt_r <= bcnt_nxt; cleft_r <= cleft_nxt;
        hdr_r <= hdr_nxt; nbad_r <= nbad_nxt; ndig_r <= ndig_nxt; chk_r <= chk_nxt;
        keep_r <= keep_nxt; lenk_r <= lenk_nxt; cdig_r <= cdig_nxt;
        nm_r <= nm_nxt; vm_r <= vm_nxt; vnum_r <= vnum_nxt; held_r <= held_nxt;
      end
      if (pop) out_v_r <= 1'b1;
      else if (res_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_r <= out_nxt;
  end

  assign res_valid = out_v_r;
  assign res       = out_r;

endmodule
`default_nettype wire

// ----- hdl/http_response_stream_parser_core.sv -----
// ----------------------------------------------------------------------------
// http_response_stream_parser_core: HTTP/1.x response stream parser
// Parses a response octet by octet and frames its body.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one action per transfer: a received octet, a peer close or a
//   parser restart. out_ch returns exactly one result per input transfer, in
//   order: result code, an optional body octet and the parsed status, version,
//   keep-alive and framing fields as they stand after that input.
//   cfg_ch writes max_body_size; write it only while the block is idle.
//   An input item is stored in the queue and its result in the result register
//   before out_ch presents it.
//   Throughput: one item per cycle while out_ch.ready keeps the result
//   register free; the parser state is updated once per item and a two-entry
//   queue sits between the classifier and the parser.
//   Reset (rst_n low, synchronous) returns the parser to the start of a status
//   line and max_body_size to all ones. A restart action clears the parser
//   but keeps max_body_size.
//   A stalled receiver holds the result register; the queue then fills and
//   in_ch.ready drops after two more transfers.
// ----------------------------------------------------------------------------
`default_nettype none
module http_response_stream_parser_core #(
  parameter int LENGTH_WIDTH = hsp_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hsp_in_if.sink     in_ch,
  hsp_out_if.source  out_ch,
  hsp_cfg_if.sink    cfg_ch
);
  import hsp_pkg::*;

  logic [31:0] max_body_r;
  logic        q_full, push, head_valid, pop;
  hsp_item_t   push_item, head_item;
  hsp_result_t res;

  // Hold the body size limit; configuration is always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= '1;
    end else if (cfg_ch.valid) begin
      max_body_r <= cfg_ch.data;
    end
  end

  // Classify and queue incoming transfers
  hsp_front u_front (
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_action    (in_ch.action),
    .in_data_byte (in_ch.data_byte),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  hsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Advance the parser and register one result per item
  hsp_back #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_body   (max_body_r),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  assign out_ch.result_code   = res.result_code;
  assign out_ch.body_valid    = res.body_valid;
  assign out_ch.body_byte     = res.body_byte;
  assign out_ch.status_value  = res.status_value;
  assign out_ch.version_major = res.version_major;
  assign out_ch.version_minor = res.version_minor;
  assign out_ch.keep_alive    = res.keep_alive;
  assign out_ch.body_length   = res.body_length;
  assign out_ch.length_known  = res.length_known;
  assign out_ch.chunked       = res.chunked;

  // The last octet of a length-delimited body carries complete with it
`ifndef SYNTHESIS
  a_body_needs_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.body_valid |->
      (out_ch.result_code == RC_NEED_MORE || out_ch.result_code == RC_COMPLETE))
    else $error("body octet carried with a failing result");
  a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.body_valid |-> out_ch.body_byte == 8'd0)
    else $error("body byte nonzero without body octet");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_ch.ready)
    else $error("input taken while queue full");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result shown right after reset");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_http_response_stream_parser_core.sv -----
// ----------------------------------------------------------------------------
// HTTP response stream parser testbench
// Drives directed and random response streams through the byte channel,
// predicts every result with a cycle-free model of the parser and compares
// each returned field. Random idling on both sides plus one long receiver
// hold-off exercise back-pressure. max_body_size is swept between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_http_response_stream_parser_core;
  import hsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [31:0] LEN_CAP = 32'hFFFF_FFFF;

  typedef enum logic [5:0] {
    P_H, P_T1, P_T2, P_P, P_SLASH, P_MAJ0, P_MAJ, P_MIN0, P_MIN, P_ST0, P_ST, P_MSG, P_NL1,
    P_HSTART, P_LWS, P_HNAME, P_SPACE, P_HVAL, P_NL2, P_NL3, P_BODY, P_CSIZE, P_CEXT, P_CSNL,
    P_CDATA, P_CDCR, P_CDNL, P_TSTART, P_TLINE, P_TLNL, P_TENDNL, P_DONE
  } parse_phase_e;

  typedef struct {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       has_code;
    logic [2:0] code;
  } stim_row_t;

  logic clk;
  logic rst_n;

  hsp_in_if  in_ch ();
  hsp_out_if out_ch ();
  hsp_cfg_if cfg_ch ();

  http_response_stream_parser_core u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Parser mirror state
  parse_phase_e ph;
  logic [7:0]  maj_r, min_r;
  logic [15:0] stat_r;
  logic [31:0] len_r, body_cnt, chunk_rem, body_limit;
  logic        hdr_seen, num_bad, num_dig, chunked_f, keep_f, lenk_f, cdig_f;
  logic [7:0]  name_m, val_m;
  logic [31:0] val_num;
  logic [2:0]  held;

  hsp_result_t result_fifo[$];
  logic        code_known_fifo[$];  // per result: directed code check
  logic [2:0]  code_pinned_fifo[$];

  int mismatches;
  int results_seen;
  int body_octets_seen;
  int code_hist[8];
  bit idle_ok;           // randomized idling enabled
  bit hold_receiver;     // long hold-off request
  bit timed_out;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit digit_q(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit ctl_q(logic [7:0] c);
    return c <= 8'd31 || c == 8'd127;
  endfunction

  function automatic bit token_q(logic [7:0] c);
    string sep;
    sep = "()<>@,;:\\\"/[]?={} \t";
    if (c > 8'd127 || ctl_q(c)) return 0;
    foreach (sep[i]) if (sep[i] == c) return 0;
    return 1;
  endfunction

  function automatic int hex_q(logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    if (digit_q(c)) return c - "0";
    if (l >= "a" && l <= "f") return l - "a" + 10;
    return -1;
  endfunction

  function automatic logic [31:0] sat_mac(logic [31:0] v, int base, int d, logic [31:0] cap);
    logic [63:0] p;
    p = 64'(v) * base + d;
    return (p > cap) ? cap : p[31:0];
  endfunction

  function automatic string word_of(bit is_val, int k);
    if (is_val) return k == 0 ? "chunked" : (k == 1 ? "close" : "keep-alive");
    return k == 0 ? "content-length" : (k == 1 ? "transfer-encoding" : "connection");
  endfunction

  function automatic logic [7:0] word_step(logic [7:0] m, logic [7:0] c, bit is_val);
    int p;
    logic [2:0] cand;
    string w;
    p = m[4:0];
    cand = m[7:5];
    for (int k = 0; k < 3; k++) begin
      w = word_of(is_val, k);
      if (p >= w.len() || w[p] != to_lower(c)) cand[k] = 1'b0;
    end
    if (p < 31) p++;
    return {cand, 5'(p)};
  endfunction

  function automatic bit word_hit(logic [7:0] m, bit is_val, int k);
    string w;
    w = word_of(is_val, k);
    return m[5 + k] && m[4:0] == w.len();
  endfunction

  function automatic void parser_clear();
    ph = P_H;
    maj_r = '0; min_r = '0; stat_r = '0; len_r = '0; body_cnt = '0; chunk_rem = '0;
    {hdr_seen, num_bad, num_dig, chunked_f, keep_f, lenk_f, cdig_f} = '0;
    name_m = 8'hE0; val_m = 8'hE0; val_num = '0; held = RC_NEED_MORE;
  endfunction

  function automatic logic [2:0] halt(logic [2:0] code);
    held = code;
    ph = P_DONE;
    return code;
  endfunction

  function automatic void take_value_octet(logic [7:0] c);
    val_m = word_step(val_m, c, 1);
    if (digit_q(c)) begin
      val_num = sat_mac(val_num, 10, c - "0", LEN_CAP);
      num_dig = 1;
    end else begin
      num_bad = 1;
    end
  endfunction

  function automatic void commit_header();
    if (word_hit(name_m, 0, 0)) begin
      if (num_dig && !num_bad) begin
        len_r = val_num;
        lenk_f = 1;
      end
    end else if (word_hit(name_m, 0, 1)) begin
      if (word_hit(val_m, 1, 0)) chunked_f = 1;
    end else if (word_hit(name_m, 0, 2)) begin
      if (word_hit(val_m, 1, 1)) keep_f = 0;
      else if (word_hit(val_m, 1, 2)) keep_f = 1;
    end
  endfunction

  // Admit one body octet against max_body_size
  function automatic logic [2:0] admit_body(output bit emit);
    emit = 0;
    if (body_cnt >= body_limit) return halt(RC_TOO_LARGE);
    body_cnt++;
    emit = 1;
    return RC_NEED_MORE;
  endfunction

  function automatic logic [2:0] parse_octet(logic [7:0] c, output bit emit);
    logic [2:0] r;
    emit = 0;
    case (ph)
      P_H:  begin if (c != "H") return halt(RC_BAD); ph = P_T1; end
      P_T1: begin if (c != "T") return halt(RC_BAD); ph = P_T2; end
      P_T2: begin if (c != "T") return halt(RC_BAD); ph = P_P; end
      P_P:  begin if (c != "P") return halt(RC_BAD); ph = P_SLASH; end
      P_SLASH: begin
        if (c != "/") return halt(RC_BAD);
        maj_r = 0; min_r = 0; ph = P_MAJ0;
      end
      P_MAJ0, P_MAJ: begin
        if (ph == P_MAJ && c == ".") begin
          ph = P_MIN0;
          return RC_NEED_MORE;
        end
        if (!digit_q(c)) return halt(RC_BAD);
        maj_r = 8'(sat_mac(maj_r, 10, c - "0", 255));
        ph = P_MAJ;
      end
      P_MIN0, P_MIN: begin
        if (ph == P_MIN && c == " ") begin
          ph = P_ST0;
          if (maj_r > 1 || (maj_r == 1 && min_r > 1)) return halt(RC_VERSION);
          keep_f = (maj_r == 1 && min_r > 0);
          return RC_NEED_MORE;
        end
        if (!digit_q(c)) return halt(RC_BAD);
        min_r = 8'(sat_mac(min_r, 10, c - "0", 255));
        ph = P_MIN;
      end
      P_ST0, P_ST: begin
        if (ph == P_ST && c == " ") begin ph = P_MSG; return RC_NEED_MORE; end
        if (ph == P_ST && c == 8'h0D) begin ph = P_NL1; return RC_NEED_MORE; end
        if (!digit_q(c)) return halt(RC_BAD);
        stat_r = 16'(sat_mac(stat_r, 10, c - "0", 65535));
        ph = P_ST;
      end
      P_MSG: begin
        if (c == 8'h0D) ph = P_NL1;
        else if (ctl_q(c)) return halt(RC_BAD);
      end
      P_NL1, P_NL2: begin
        if (c != 8'h0A) return halt(RC_BAD);
        ph = P_HSTART;
      end
      P_HSTART: begin
        if (c == 8'h0D) begin ph = P_NL3; return RC_NEED_MORE; end
        if (hdr_seen && (c == " " || c == 8'h09)) begin ph = P_LWS; return RC_NEED_MORE; end
        if (!token_q(c)) return halt(RC_BAD);
        hdr_seen = 1; num_bad = 0; num_dig = 0;
        name_m = word_step(8'hE0, c, 0);
        val_m = 8'hE0; val_num = 0;
        ph = P_HNAME;
      end
      P_LWS: begin
        if (c == 8'h0D) begin ph = P_NL2; return RC_NEED_MORE; end
        if (c == " " || c == 8'h09) return RC_NEED_MORE;
        if (ctl_q(c)) return halt(RC_BAD);
        take_value_octet(c);
        ph = P_HVAL;
      end
      P_HNAME: begin
        if (c == ":") begin ph = P_SPACE; return RC_NEED_MORE; end
        if (!token_q(c)) return halt(RC_BAD);
        name_m = word_step(name_m, c, 0);
      end
      P_SPACE: begin
        if (c == " ") ph = P_HVAL;
        else if (c == 8'h0D) ph = P_NL2;
        else return halt(RC_BAD);
      end
      P_HVAL: begin
        if (c == 8'h0D) begin commit_header(); ph = P_NL2; return RC_NEED_MORE; end
        if (ctl_q(c)) return halt(RC_BAD);
        take_value_octet(c);
      end
      P_NL3: begin
        if (c != 8'h0A) return halt(RC_BAD);
        if (stat_r == 101) return halt(RC_SWITCHING);
        if (stat_r >= 100 && stat_r < 200) begin
          parser_clear();
          return RC_NEED_MORE;
        end
        body_cnt = 0;
        if (stat_r == 204 || stat_r == 304) return halt(RC_COMPLETE);
        if (chunked_f) begin
          chunk_rem = 0; cdig_f = 0; ph = P_CSIZE;
          return RC_NEED_MORE;
        end
        if (lenk_f && len_r == 0) return halt(RC_COMPLETE);
        ph = P_BODY;
      end
      P_BODY: begin
        r = admit_body(emit);
        if (r != RC_NEED_MORE) return r;
        if (lenk_f && body_cnt >= len_r) return halt(RC_COMPLETE);
      end
      P_CSIZE: begin
        if (hex_q(c) >= 0) begin
          cdig_f = 1;
          chunk_rem = sat_mac(chunk_rem, 16, hex_q(c), LEN_CAP);
        end else if ((c == ";" || c == 8'h0D) && cdig_f) begin
          ph = (c == ";") ? P_CEXT : P_CSNL;
        end else begin
          return halt(RC_BAD);
        end
      end
      P_CEXT: if (c == 8'h0D) ph = P_CSNL;
      P_CSNL: begin
        if (c != 8'h0A) return halt(RC_BAD);
        ph = (chunk_rem == 0) ? P_TSTART : P_CDATA;
      end
      P_CDATA: begin
        r = admit_body(emit);
        if (r != RC_NEED_MORE) return r;
        chunk_rem--;
        if (chunk_rem == 0) ph = P_CDCR;
      end
      P_CDCR: begin
        if (c != 8'h0D) return halt(RC_BAD);
        ph = P_CDNL;
      end
      P_CDNL: begin
        if (c != 8'h0A) return halt(RC_BAD);
        chunk_rem = 0; cdig_f = 0; ph = P_CSIZE;
      end
      P_TSTART: ph = (c == 8'h0D) ? P_TENDNL : P_TLINE;
      P_TLINE:  if (c == 8'h0D) ph = P_TLNL;
      P_TLNL: begin
        if (c != 8'h0A) return halt(RC_BAD);
        ph = P_TSTART;
      end
      P_TENDNL: begin
        if (c != 8'h0A) return halt(RC_BAD);
        return halt(RC_COMPLETE);
      end
      default: return held;
    endcase
    return RC_NEED_MORE;
  endfunction

  // Advance the mirror by one input item and return the expected result
  function automatic hsp_result_t predict_result(logic [1:0] act, logic [7:0] c);
    hsp_result_t res;
    bit emit;
    logic [2:0] code;
    emit = 0;
    code = RC_NEED_MORE;
    if (act == ACT_BYTE) begin
      code = parse_octet(c, emit);
    end else if (act == ACT_CLOSE) begin
      if (ph == P_DONE) code = held;
      else if (ph == P_BODY && !lenk_f) begin
        keep_f = 0;
        code = halt(RC_COMPLETE);
      end else code = halt(RC_BAD);
    end else if (act == ACT_RESTART) begin
      parser_clear();
    end
    res.result_code   = code;
    res.body_valid    = emit;
    res.body_byte     = emit ? c : 8'd0;
    res.status_value  = stat_r;
    res.version_major = maj_r;
    res.version_minor = min_r;
    res.keep_alive    = keep_f;
    res.body_length   = len_r;
    res.length_known  = lenk_f;
    res.chunked       = chunked_f;
    return res;
  endfunction

  // ---------------------------------------------------------------- sender
  // Send one item: predict at acceptance, hold valid until the transfer.
  task automatic send_item(logic [1:0] act, logic [7:0] c, bit pin, logic [2:0] pin_code);
    hsp_result_t exp_res;
    while (idle_ok && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_byte <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_res = predict_result(act, c);
    result_fifo      = {result_fifo, exp_res};
    code_known_fifo  = {code_known_fifo, pin};
    code_pinned_fifo = {code_pinned_fifo, pin_code};
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(ACT_BYTE, s[i], 0, 0);
  endtask

  task automatic park_sender();
    in_ch.valid <= 1'b0;
  endtask

  // Let every expected result return, then give in-flight items time to land.
  task automatic drain();
    park_sender();
    while (result_fifo.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    body_limit = v;
  endtask

  function automatic string hex_count(int n);
    return $sformatf("%0x", n);
  endfunction

  // Build one response with random content, mostly well formed
  task automatic send_random_response();
    int kind, n, status;
    bit broken;
    string s;
    kind = $urandom_range(9);
    broken = ($urandom_range(9) == 0);
    case ($urandom_range(11))
      0: status = 101;
      1: status = 100 + $urandom_range(3);
      2: status = 204;
      3: status = 304;
      default: status = 200 + $urandom_range(400);
    endcase
    s = $sformatf("HTTP/1.%0d %0d", $urandom_range(1), status);
    if ($urandom_range(1)) s = {s, " OK\x80"};
    s = {s, "\r\n"};
    if ($urandom_range(2) == 0) begin
      s = {s, "Connection: "};
      if ($urandom_range(1)) s = {s, "close"};
      else s = {s, "Keep-Alive"};
      s = {s, "\r\n"};
    end
    if ($urandom_range(3) == 0) s = {s, "X-Tag: a\xff\r\n  more\r\n"};
    n = $urandom_range(8);
    if (kind < 4) begin
      s = {s, "Transfer-Encoding: chunked\r\n\r\n"};
      repeat ($urandom_range(2)) begin
        n = 1 + $urandom_range(5);
        s = {s, hex_count(n)};
        if ($urandom_range(1)) s = {s, ";x=y"};
        s = {s, "\r\n"};
        repeat (n) s = {s, string'(8'($urandom_range(255, 1)))};
        s = {s, "\r\n"};
      end
      s = {s, "0\r\n"};
      if ($urandom_range(1)) s = {s, "T: v\r\n"};
      s = {s, "\r\n"};
    end else if (kind < 8) begin
      s = {s, $sformatf("content-length: %0d\r\n\r\n", n)};
      repeat (n) s = {s, string'(8'($urandom_range(255, 1)))};
    end else begin
      s = {s, "\r\n"};
      repeat (n) s = {s, string'(8'($urandom_range(255, 1)))};
    end
    if (broken) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255, 1));
    send_text(s);
    if (kind >= 8) send_item(ACT_CLOSE, 8'($urandom), 0, 0);
    if ($urandom_range(9) == 0) send_item(2'd3, 8'($urandom), 0, 0);
    if ($urandom_range(7) == 0) send_item(ACT_BYTE, 8'($urandom), 0, 0);
    send_item(ACT_RESTART, 8'($urandom), 0, 0);
  endtask

  // ---------------------------------------------------------------- receiver
  int hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_receiver && hold_left == 0) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_ok && $urandom_range(99) < 30);
      end
    end
  end

  // ---------------------------------------------------------------- checker
  hsp_result_t got, want;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.result_code   = out_ch.result_code;
      got.body_valid    = out_ch.body_valid;
      got.body_byte     = out_ch.body_byte;
      got.status_value  = out_ch.status_value;
      got.version_major = out_ch.version_major;
      got.version_minor = out_ch.version_minor;
      got.keep_alive    = out_ch.keep_alive;
      got.body_length   = out_ch.body_length;
      got.length_known  = out_ch.length_known;
      got.chunked       = out_ch.chunked;
      results_seen++;
      if (result_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = result_fifo.pop_front();
        // a typed-in code in the directed table replaces the predicted code in the check
        if (code_known_fifo.pop_front() && code_pinned_fifo[0] != want.result_code)
          want.result_code = code_pinned_fifo[0];
        void'(code_pinned_fifo.pop_front());
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected %p, got %p", mismatches, want, got);
        end
        code_hist[got.result_code]++;
        if (got.body_valid) body_octets_seen++;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || cfg_ch.valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- directed table
  stim_row_t dir_rows[$];

  task automatic add_row(logic [1:0] a, logic [7:0] c, bit pin, logic [2:0] code);
    stim_row_t r;
    r.action = a; r.data_byte = c; r.has_code = pin; r.code = code;
    dir_rows = {dir_rows, r};
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.action = ACT_BYTE; in_ch.data_byte = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    idle_ok = 0; hold_receiver = 0;
    mismatches = 0; results_seen = 0; body_octets_seen = 0; quiet_cycles = 0;
    parser_clear();
    body_limit = 32'hFFFF_FFFF;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bad first octet, held code, close while done, restart, unused action
    add_row(ACT_BYTE, 8'hFF, 1, RC_BAD);
    add_row(ACT_BYTE, "H", 1, RC_BAD);
    add_row(ACT_CLOSE, 8'h00, 1, RC_BAD);
    add_row(ACT_RESTART, 8'hFF, 1, RC_NEED_MORE);
    add_row(2'd3, 8'h55, 1, RC_NEED_MORE);
    add_row(ACT_CLOSE, 8'h00, 1, RC_BAD);
    add_row(ACT_RESTART, 8'h00, 1, RC_NEED_MORE);
    foreach (dir_rows[i]) send_item(dir_rows[i].action, dir_rows[i].data_byte,
                                    dir_rows[i].has_code, dir_rows[i].code);
    // unsupported version, saturating numbers, 101, interim 1xx, 204
    send_text("HTTP/1.2 "); send_item(ACT_RESTART, 0, 0, 0);
    send_text("HTTP/999.999 "); send_item(ACT_RESTART, 0, 0, 0);
    send_text("HTTP/1.1 99999\r\ncontent-length: 99999999999\r\n\r\n");
    send_item(ACT_RESTART, 0, 0, 0);
    send_text("HTTP/1.1 101\r\n\r\nX"); send_item(ACT_RESTART, 0, 0, 0);
    send_text("HTTP/1.1 100 Go\r\n\r\nHTTP/1.0 204 N\r\nBad Name: x\r\n");
    send_item(ACT_RESTART, 0, 0, 0);
    send_text("HTTP/1.0 200 OK\r\nConnection:\r\n keep-alive\r\nContent-Length: 3\r\n");
    send_text("Content-Length: +1\r\n\r\nabc"); send_item(ACT_RESTART, 0, 0, 0);
    drain();

    // tiny limit: too large on a close-delimited body, then zero limit
    write_limit(32'd2);
    send_text("HTTP/1.1 200 OK\r\n\r\nxyz"); send_item(ACT_CLOSE, 0, 0, 0);
    send_item(ACT_RESTART, 0, 0, 0);
    drain();
    write_limit(32'd0);
    send_text("HTTP/1.1 200 OK\r\nTransfer-Encoding: CHUNKED\r\n\r\n1\r\nq");
    send_item(ACT_RESTART, 0, 0, 0);
    drain();
    write_limit(32'hFFFF_FFFF);

    // random phase 1 with idling, receiver held off at the start
    idle_ok = 1;
    hold_receiver = 1;
    repeat (2) @(posedge clk);
    hold_receiver = 0;
    repeat (1) send_random_response();
    drain();
    write_limit(32'd5);
    repeat (1) send_random_response();
    drain();
    write_limit(32'hFFFF_FFFF);
    // back-to-back stretch, then idling again
    idle_ok = 0;
    repeat (1) send_random_response();
    idle_ok = 1;
    drain();

    $display("checked %0d results carrying %0d body octets; need=%0d done=%0d bad=%0d",
             results_seen, body_octets_seen, code_hist[0], code_hist[1], code_hist[2]);
    $display("  version=%0d oversize=%0d switching=%0d", code_hist[3], code_hist[4],
             code_hist[5]);
    if (mismatches == 0 && result_fifo.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
